FILE: sv/wcc_pkg.sv
// Shared types and constants for the wall column texture coordinate core.
// No dependencies; imported by every module of the block but wcc_div.
package wcc_pkg;

  localparam int TEX_SIZE    = 64;
  localparam int TEX_BITS    = 6;
  localparam int DIR_FRAC    = 14;
  localparam int POS_W       = 40;
  localparam int FIRST_W     = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  typedef enum logic {
    KIND_LOAD,
    KIND_ROW
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_SCALE
  } back_state_t;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         column;
    logic               hit_side;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0]        wall_dist;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
    logic [9:0]         draw_start;
    logic [9:0]         draw_end;
    logic [15:0]        wall_height;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_column;
    logic [8:0] out_row;
    logic [5:0] tex_col;
    logic [5:0] tex_row;
    logic       last_row;
  } out_item_t;

  // Classified command held in the queue between front and back.
  typedef struct packed {
    cmd_kind_t                 kind;
    logic [9:0]                column;
    logic [23:0]               tex_base;
    logic [23:0]               tex_dist;
    logic signed [15:0]        tex_dir;
    logic                      tex_add;
    logic                      tex_mirror;
    logic [9:0]                start_row;
    logic [9:0]                end_row;
    logic [15:0]               wall_height;
    logic signed [FIRST_W-1:0] first;
    logic                      span_ok;
  } cmd_t;

endpackage

FILE: sv/wcc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by wcc_back for the texture row step.
module wcc_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: sv/wcc_front.sv
// Front end: accepts items, classifies them into commands and queues them.
// Depends on wcc_pkg.
module wcc_front #(
  parameter int SCREEN_ROWS = 512,
  parameter int SCREEN_COLS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  wcc_pkg::in_item_t req,
  input  logic             req_valid,
  output logic             req_ready,
  output wcc_pkg::cmd_t    cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);

  import wcc_pkg::*;

  localparam logic [FIRST_W-1:0] HALF_ROWS = FIRST_W'(SCREEN_ROWS / 2);

  cmd_t              entry;
  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic [15:0]       lh_fix;
  logic [9:0]        end_clamp;

  // Classify: pick the axis terms, fix up line height, clamp the span.
  always_comb begin
    lh_fix    = (req.wall_height == 16'd0) ? 16'd1 : req.wall_height;
    end_clamp = ({1'b0, req.draw_end} > 11'(SCREEN_ROWS)) ? 10'(SCREEN_ROWS)
                                                          : req.draw_end;
    entry             = '0;
    entry.kind        = (req.opcode == OP_ROW) ? KIND_ROW : KIND_LOAD;
    entry.column      = req.column;
    entry.tex_dist    = req.wall_dist;
    entry.start_row   = req.draw_start;
    entry.end_row     = end_clamp;
    entry.wall_height = lh_fix;
    entry.first       = $signed({{(FIRST_W-10){1'b0}}, req.draw_start})
                      - $signed(HALF_ROWS)
                      + $signed({{(FIRST_W-15){1'b0}}, lh_fix[15:1]});
    entry.span_ok     = (req.draw_start < end_clamp)
                      && ({1'b0, req.column} < 11'(SCREEN_COLS));
    if (req.hit_side == 1'b0) begin
      entry.tex_base   = req.player_y;
      entry.tex_dir    = req.dir_y;
      entry.tex_add    = req.dir_x > 16'sd0;
      entry.tex_mirror = req.dir_x < 16'sd0;
    end else begin
      entry.tex_base   = req.player_x;
      entry.tex_dir    = req.dir_x;
      entry.tex_add    = req.dir_y > 16'sd0;
      entry.tex_mirror = req.dir_y > 16'sd0;
    end
  end

  assign req_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push      = req_valid && req_ready;
  assign cmd_valid = count != '0;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

endmodule

FILE: sv/wcc_back.sv
// Back end: column set-up (texture column, step divide, start position)
// and the row emitter with its output register. Depends on wcc_pkg, wcc_div.
module wcc_back #(
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  wcc_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  output wcc_pkg::out_item_t rsp,
  output logic               rsp_valid,
  input  logic               rsp_ready
);

  import wcc_pkg::*;

  localparam int STEP_W  = FRAC_BITS + TEX_BITS + 1;
  localparam int PROD_W  = FIRST_W + STEP_W + 1;
  localparam int EXT_W   = (PROD_W > POS_W) ? PROD_W : POS_W;
  localparam int COL_LSB = FRAC_BITS + DIR_FRAC - TEX_BITS;
  localparam int SUM_W   = 42;
  localparam logic [STEP_W-1:0] STEP_NUM = STEP_W'(TEX_SIZE) << FRAC_BITS;

  back_state_t state, state_next;

  logic                      take_load;
  logic                      emit;
  logic                      do_scale;
  logic                      slot_free;
  logic                      div_done;
  logic [STEP_W-1:0]         div_quo;

  logic                      span_active;
  logic [9:0]                cur_column;
  logic [9:0]                cur_row;
  logic [9:0]                end_row;
  logic [TEX_BITS-1:0]       held_tex_col;
  logic [STEP_W-1:0]         row_step;
  logic [POS_W-1:0]          tex_position;

  logic [23:0]               tex_base;
  logic                      tex_add;
  logic                      tex_mirror;
  logic signed [FIRST_W-1:0] first;
  logic signed [40:0]        tex_prod;

  logic signed [SUM_W-1:0]   base_ext;
  logic signed [SUM_W-1:0]   prod_ext;
  logic signed [SUM_W-1:0]   tex_sum;
  logic [SUM_W-1:0]          tex_mag;
  logic [TEX_BITS-1:0]       col_raw;
  logic signed [PROD_W-1:0]  pos_prod;
  logic signed [EXT_W-1:0]   pos_ext;
  logic [TEX_BITS-1:0]       tex_row_v;
  logic                      is_last;

  wcc_div #(
    .DVD_W(STEP_W),
    .DVS_W(16)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (take_load),
    .dividend (STEP_NUM),
    .divisor  (cmd.wall_height),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign slot_free = !rsp_valid || rsp_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.kind == KIND_LOAD) state_next = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (div_done) state_next = BK_SCALE;
      end
      BK_SCALE: state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd_pop   = 1'b0;
    take_load = 1'b0;
    emit      = 1'b0;
    do_scale  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == KIND_LOAD) begin
            cmd_pop   = 1'b1;
            take_load = 1'b1;
          end else if (!span_active) begin
            cmd_pop = 1'b1;
          end else if (slot_free) begin
            cmd_pop = 1'b1;
            emit    = 1'b1;
          end
        end
      end
      BK_DIVIDE: ;
      BK_SCALE:  do_scale = 1'b1;
      default:   ;
    endcase
  end

  // Texture column from |base*2^14 +/- dist*dir|, mirrored as needed.
  always_comb begin
    base_ext = $signed({4'b0, tex_base, {DIR_FRAC{1'b0}}});
    prod_ext = SUM_W'(tex_prod);
    tex_sum  = tex_add ? base_ext + prod_ext : base_ext - prod_ext;
    tex_mag  = tex_sum[SUM_W-1] ? -tex_sum : tex_sum;
    col_raw  = tex_mag[COL_LSB +: TEX_BITS];
  end

  assign pos_prod = first * $signed({1'b0, row_step});
  assign pos_ext  = EXT_W'(pos_prod);

  // Integer part truncated toward zero, low bits only.
  assign tex_row_v = tex_position[FRAC_BITS +: TEX_BITS]
                   + TEX_BITS'(tex_position[POS_W-1] && (|tex_position[FRAC_BITS-1:0]));
  assign is_last   = ({1'b0, cur_row} + 11'd1) >= {1'b0, end_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      span_active <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (take_load) begin
        span_active <= cmd.span_ok;
      end else if (emit && is_last) begin
        span_active <= 1'b0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_load) begin
      cur_column <= cmd.column;
      cur_row    <= cmd.start_row;
      end_row    <= cmd.end_row;
      tex_base   <= cmd.tex_base;
      tex_add    <= cmd.tex_add;
      tex_mirror <= cmd.tex_mirror;
      first      <= cmd.first;
      tex_prod   <= $signed({1'b0, cmd.tex_dist}) * cmd.tex_dir;
    end
    if (state == BK_DIVIDE) begin
      held_tex_col <= tex_mirror ? ~col_raw : col_raw;
    end
    if (state == BK_DIVIDE && div_done) begin
      row_step <= div_quo;
    end
    if (do_scale) begin
      tex_position <= pos_ext[POS_W-1:0];
    end
    if (emit) begin
      rsp.out_column <= cur_column;
      rsp.out_row    <= cur_row[8:0];
      rsp.tex_col    <= held_tex_col;
      rsp.tex_row    <= tex_row_v;
      rsp.last_row   <= is_last;
      tex_position   <= tex_position + POS_W'(row_step);
      cur_row        <= cur_row + 10'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_row_in_setup: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> !emit)
    else $error("row emitted during column set-up");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == BK_DIVIDE)
    else $error("divider finished outside divide state");

  a_last_closes_span: assert property (@(posedge clk) disable iff (rst)
    emit && is_last |=> !span_active)
    else $error("span still active after last row");

  a_span_in_range: assert property (@(posedge clk) disable iff (rst)
    span_active |-> cur_row < end_row)
    else $error("active span row past end row");
`endif

endmodule

FILE: sv/wall_column_texture_coords_core.sv
// Wall column texture coordinate core: top level. Depends on wcc_pkg, wcc_front, wcc_back.
// Row items: queued in the front, registered at the output; one row per cycle sustained
//   while rsp_ready is high and no load is in set-up. Load items: the back end's set-up
//   runs the one-bit-per-cycle divider for the row step; rows queue up meanwhile.
// Reset (rst, synchronous, active high) clears the queue, set-up state, span and
//   output valid; no span is active after reset.
module wall_column_texture_coords_core #(
  parameter int SCREEN_ROWS = 512,
  parameter int SCREEN_COLS = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  wcc_pkg::in_item_t  req,
  input  logic               req_valid,
  output logic               req_ready,
  output wcc_pkg::out_item_t rsp,
  output logic               rsp_valid,
  input  logic               rsp_ready
);

  import wcc_pkg::*;

  // Command queue between the classifier and the set-up/row engine.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Front: accept each item, resolve axis selection, clamps and the
  // start offset, then hold it in a short queue so the input only waits,
  // on a set-up that is still dividing or a held result, once the queue is full.
  wcc_front #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Back: run column set-up for loads, emit one row per row command while
  // a span is active, drop row commands with no span. The output register
  // lets loads and dropped rows keep popping while the consumer holds a
  // result; a row to emit waits for the register to free up.
  wcc_back #(
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
